// File: src/gbig_pkg.sv
// package: shared constants, types and config struct for the bilinear gradient block
package gbig_pkg;

  localparam int unsigned MaxRows  = 256;
  localparam int unsigned MaxCols  = 256;
  localparam int unsigned RowBits  = $clog2(MaxRows);
  localparam int unsigned ColBits  = $clog2(MaxCols);
  localparam int unsigned AddrBits = RowBits + ColBits;
  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgOriginX  = 3'd0,
    CfgOriginY  = 3'd1,
    CfgInvRes   = 3'd2,
    CfgOutside  = 3'd3,
    CfgWidth    = 3'd4,
    CfgHeight   = 3'd5
  } cfg_idx_e;

  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  cell_row;
    logic [7:0]  cell_col;
    logic signed [31:0] cell_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic               in_range;
  } out_item_t;

  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] inv_resolution;
    logic [31:0] outside_value;
    logic [8:0]  grid_width;
    logic [8:0]  grid_height;
  } cfg_t;

endpackage

// File: src/gbig_if.sv
// interface: valid/ready channels for input and result transactions
interface gbig_in_if;
  import gbig_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gbig_out_if;
  import gbig_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/gbig_locate.sv
// module: one axis coordinate mapping, two register stages
module gbig_locate (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] p_i,
  input  logic [31:0] org_i,
  input  logic [31:0] inv_res_i,
  input  logic [8:0]  lim_i,
  output logic        ok_o,
  output logic [7:0]  idx_o,
  output logic [15:0] frac_o
);
  import gbig_pkg::*;

  logic signed [32:0] d_d;
  logic [31:0] dmag_q;
  logic        dneg_q;
  logic [8:0]  lim_q;
  logic [63:0] m_d;
  logic [63:0] h_d;
  logic [31:0] i_d;
  logic [8:0]  w_d;

  assign d_d = $signed({p_i[31], p_i}) - $signed({org_i[31], org_i});

  // stage a: difference and limit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dneg_q <= d_d[32];
      dmag_q <= d_d[31:0];
      lim_q  <= lim_i;
    end
  end

  // stage b: multiply and range check
  assign m_d = 64'(dmag_q) * 64'(inv_res_i);
  assign h_d = m_d - 64'h8000_0000;
  assign i_d = h_d[63:32];
  assign w_d = lim_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ok_o   <= !dneg_q && (m_d >= 64'h8000_0000) && (w_d >= 9'd2)
                && (i_d <= 32'(w_d - 9'd2));
      idx_o  <= i_d[7:0];
      frac_o <= h_d[31:16];
    end
  end
endmodule

// File: src/gbig_grad.sv
// module: one gradient lane, magnitude truncation, scale and saturate over two stages
module gbig_grad (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic signed [32:0] da_i,
  input  logic signed [32:0] db_i,
  input  logic [15:0] t_i,
  input  logic [31:0] inv_res_i,
  output logic [31:0] grad_o
);
  import gbig_pkg::*;

  logic signed [51:0] s_d;
  logic [51:0] mag_d;
  logic [35:0] m_q;
  logic        neg_q;
  logic [67:0] p_full;
  logic [51:0] p_d;

  assign s_d = $signed({1'b0, 17'h10000 - 17'(t_i)}) * da_i
             + $signed({1'b0, t_i}) * db_i;
  assign mag_d = s_d[51] ? 52'(-s_d) : 52'(s_d);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= s_d[51];
      m_q   <= mag_d[51:16];
    end
  end

  assign p_full = 68'(m_q) * 68'(inv_res_i);
  assign p_d    = p_full[67:16];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q) begin
        grad_o <= (p_d > 52'h8000_0000) ? 32'h8000_0000 : 32'(-p_d[31:0]);
      end else begin
        grad_o <= (p_d > 52'h7FFF_FFFF) ? 32'h7FFF_FFFF : p_d[31:0];
      end
    end
  end
endmodule

// File: src/grid_bilinear_interp_gradient.sv
// top level: banked grid store with pipelined bilinear value and gradient query
// an accepted query gives its result once it reaches the last pipeline stage
// throughput: one transaction per cycle while the output is not stalled; writes and queries may interleave freely
// the whole pipeline advances together; a stall at the output holds every stage
// reset clears valid bits and sets the configuration to its defaults; the cell store is not cleared
module grid_bilinear_interp_gradient (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [gbig_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [31:0]                cfg_data_i,
  gbig_in_if.sink                    in_if,
  gbig_out_if.source                 out_if
);
  import gbig_pkg::*;

  localparam int unsigned Stages = 6;

  cfg_t cfg_q;
  logic en;
  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] qry_q;

  // pipeline advances unless a query result is waiting at the output
  assign en          = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{origin_x: 32'd0, origin_y: 32'd0, inv_resolution: 32'h0001_0000,
                 outside_value: 32'd0, grid_width: 9'd256, grid_height: 9'd256};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOriginX: cfg_q.origin_x       <= cfg_data_i;
        CfgOriginY: cfg_q.origin_y       <= cfg_data_i;
        CfgInvRes:  cfg_q.inv_resolution <= cfg_data_i;
        CfgOutside: cfg_q.outside_value  <= cfg_data_i;
        CfgWidth:   cfg_q.grid_width     <= cfg_data_i[8:0];
        CfgHeight:  cfg_q.grid_height    <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // valid and kind bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      qry_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], in_if.valid};
      qry_q <= {qry_q[Stages-2:0], in_if.data.kind == KindQuery};
    end
  end

  // grid sizes beyond the store are clamped to its rows and columns
  logic [8:0] lim_x, lim_y;
  assign lim_x = (cfg_q.grid_width > 9'(MaxCols)) ? 9'(MaxCols) : cfg_q.grid_width;
  assign lim_y = (cfg_q.grid_height > 9'(MaxRows)) ? 9'(MaxRows) : cfg_q.grid_height;

  // stages 1-2: coordinate mapping per axis
  logic       okx, oky;
  logic [7:0] ix, iy;
  logic [15:0] tx, ty;

  gbig_locate u_loc_x (
    .clk_i, .en_i(en), .p_i(in_if.data.query_x), .org_i(cfg_q.origin_x),
    .inv_res_i(cfg_q.inv_resolution), .lim_i(lim_x),
    .ok_o(okx), .idx_o(ix), .frac_o(tx)
  );
  gbig_locate u_loc_y (
    .clk_i, .en_i(en), .p_i(in_if.data.query_y), .org_i(cfg_q.origin_y),
    .inv_res_i(cfg_q.inv_resolution), .lim_i(lim_y),
    .ok_o(oky), .idx_o(iy), .frac_o(ty)
  );

  // write path is delayed to stage 2 so it stays in order with queries
  logic [7:0]  wr_row_q [2];
  logic [7:0]  wr_col_q [2];
  logic [31:0] wr_val_q [2];
  always_ff @(posedge clk_i) begin
    if (en) begin
      wr_row_q[0] <= in_if.data.cell_row;
      wr_col_q[0] <= in_if.data.cell_col;
      wr_val_q[0] <= in_if.data.cell_value;
      wr_row_q[1] <= wr_row_q[0];
      wr_col_q[1] <= wr_col_q[0];
      wr_val_q[1] <= wr_val_q[0];
    end
  end

  // four banks by row and column parity; each bank 128x128
  localparam int unsigned BankAddr = AddrBits - 2;
  logic        wr_en;
  logic [1:0]  wr_bank;
  logic [BankAddr-1:0] wr_addr;

  assign wr_en   = en && vld_q[1] && !qry_q[1];
  assign wr_bank = {wr_row_q[1][0], wr_col_q[1][0]};
  assign wr_addr = {wr_row_q[1][RowBits-1:1], wr_col_q[1][ColBits-1:1]};

  // read addresses for each bank; rows iy and iy+1 and cols ix and ix+1
  logic [RowBits-1:0] r0, r1;
  logic [ColBits-1:0] c0, c1;
  assign r0 = iy;
  assign r1 = iy + 1'b1;
  assign c0 = ix;
  assign c1 = ix + 1'b1;

  logic [31:0] rd_q [4];
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BankId = 2'(b);
    logic [31:0] mem_q [2**BankAddr];
    logic [31:0] rdata_q;
    logic [RowBits-1:0] rr;
    logic [ColBits-1:0] cc;
    assign rr = (r0[0] == BankId[1]) ? r0 : r1;
    assign cc = (c0[0] == BankId[0]) ? c0 : c1;
    always_ff @(posedge clk_i) begin
      if (wr_en && wr_bank == BankId) begin
        mem_q[wr_addr] <= wr_val_q[1];
      end
      if (en) begin
        rdata_q <= mem_q[{rr[RowBits-1:1], cc[ColBits-1:1]}];
      end
    end
    assign rd_q[b] = rdata_q;
  end

  // stage 3 side data
  logic        ok3_q;
  logic [1:0]  par3_q;
  logic [15:0] tx3_q, ty3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      ok3_q  <= okx && oky;
      par3_q <= {iy[0], ix[0]};
      tx3_q  <= tx;
      ty3_q  <= ty;
    end
  end

  // unscramble banks into the four corners
  logic signed [31:0] v00, v10, v01, v11;
  always_comb begin
    v00 = rd_q[{par3_q[1],  par3_q[0]}];
    v10 = rd_q[{par3_q[1], ~par3_q[0]}];
    v01 = rd_q[{~par3_q[1], par3_q[0]}];
    v11 = rd_q[{~par3_q[1], ~par3_q[0]}];
  end

  // stage 4: corner products with x weights, and differences for gradients
  logic signed [49:0] a0_q, a1_q;
  logic signed [32:0] dx0_q, dx1_q, dy0_q, dy1_q;
  logic [15:0] tx4_q, ty4_q;
  logic        ok4_q;
  logic signed [17:0] wx0, wx1;
  assign wx0 = 18'sh10000 - $signed({2'b0, tx3_q});
  assign wx1 = $signed({2'b0, tx3_q});
  always_ff @(posedge clk_i) begin
    if (en) begin
      // row sums in Q.16 fraction of x, exact
      a0_q  <= 50'(v00) * 50'(wx0) + 50'(v10) * 50'(wx1);
      a1_q  <= 50'(v01) * 50'(wx0) + 50'(v11) * 50'(wx1);
      dx0_q <= 33'(v10) - 33'(v00);
      dx1_q <= 33'(v11) - 33'(v01);
      dy0_q <= 33'(v01) - 33'(v00);
      dy1_q <= 33'(v11) - 33'(v10);
      tx4_q <= tx3_q;
      ty4_q <= ty3_q;
      ok4_q <= ok3_q;
    end
  end

  // stage 5: y weighting; gradient lanes cover stages 5 and 6
  logic signed [66:0] s5;
  logic signed [17:0] wy0, wy1;
  logic [31:0] val5_q, val6_q;
  logic        ok5_q, ok6_q;
  assign wy0 = 18'sh10000 - $signed({2'b0, ty4_q});
  assign wy1 = $signed({2'b0, ty4_q});
  assign s5  = 67'(a0_q) * 67'(wy0) + 67'(a1_q) * 67'(wy1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      val5_q <= s5[63:32];
      ok5_q  <= ok4_q;
      val6_q <= val5_q;
      ok6_q  <= ok5_q;
    end
  end

  logic [31:0] gx, gy;
  gbig_grad u_grad_x (
    .clk_i, .en_i(en), .da_i(dx0_q), .db_i(dx1_q), .t_i(ty4_q),
    .inv_res_i(cfg_q.inv_resolution), .grad_o(gx)
  );
  gbig_grad u_grad_y (
    .clk_i, .en_i(en), .da_i(dy0_q), .db_i(dy1_q), .t_i(tx4_q),
    .inv_res_i(cfg_q.inv_resolution), .grad_o(gy)
  );

  // result mux at the output register
  assign out_if.valid         = vld_q[Stages-1] && qry_q[Stages-1];
  assign out_if.data.value    = ok6_q ? val6_q : cfg_q.outside_value;
  assign out_if.data.grad_x   = ok6_q ? gx : 32'd0;
  assign out_if.data.grad_y   = ok6_q ? gy : 32'd0;
  assign out_if.data.in_range = ok6_q;

  // a held result must stay valid and keep its in_range flag while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data.in_range))
    else $error("result changed while stalled");

  // input ready follows the output stage
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[Stages-1] |-> in_if.ready)
    else $error("stall with empty output stage");

  // an accepted query is registered into the first pipeline stage
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready && in_if.data.kind == KindQuery && en
    |=> qry_q[0] && vld_q[0])
    else $error("query lost at entry");

endmodule
